// ===== rtl/core/jfies_pkg.sv =====
// ----------------------------------------------------------------------------
// jfies_pkg
// Shared types and constants for the JPEG first-image end scanner: status
// codes, marker byte values and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package jfies_pkg;

    localparam int STATUS_W  = 3;
    localparam int END_OFS_W = 32;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STRUCT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

    // marker bytes
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_EOI  = 8'hD9;
    localparam logic [7:0] BYTE_SOS  = 8'hDA;
    localparam logic [7:0] BYTE_TEM  = 8'h01;
    localparam logic [7:0] BYTE_RST0 = 8'hD0;
    localparam logic [7:0] BYTE_RST7 = 8'hD7;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [END_OFS_W-1:0] end_offset;
    } jfies_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/jfies_parser.sv =====
// ----------------------------------------------------------------------------
// jfies_parser
// Per-byte marker/segment state machine. Updates its state on each input
// beat until a decision is made and flags a result beat in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jfies_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   beat,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_byte,
    output logic                        res_fire,
    output jfies_pkg::jfies_result_t    res
);
    import jfies_pkg::*;

    localparam logic [3:0] PH_SOI0    = 4'd0;
    localparam logic [3:0] PH_SOI1    = 4'd1;
    localparam logic [3:0] PH_NEED_FF = 4'd2;
    localparam logic [3:0] PH_MARKER  = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_SKIP    = 4'd6;
    localparam logic [3:0] PH_ENTROPY = 4'd7;
    localparam logic [3:0] PH_ENT_FF  = 4'd8;

    logic [3:0]             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic [15:0]            seg_rem_reg, seg_rem_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic                   scan_seg_reg, scan_seg_next;
    logic                   decided_reg, decided_next;

    always_comb begin
        logic [OFFSET_BITS-1:0] pos_inc;
        logic [15:0]            seg_len;
        logic [15:0]            seg_dec;
        logic [3:0]             after_seg;
        logic                   do_marker;
        logic                   is_rst;

        pos_inc   = position_reg + OFFSET_BITS'(1);
        seg_len   = {len_hi_reg, data_byte};
        seg_dec   = seg_rem_reg - 16'd1;
        after_seg = scan_seg_reg ? PH_ENTROPY : PH_NEED_FF;
        do_marker = 1'b0;
        is_rst    = (data_byte >= BYTE_RST0) && (data_byte <= BYTE_RST7);

        phase_next    = phase_reg;
        position_next = position_reg;
        seg_rem_next  = seg_rem_reg;
        len_hi_next   = len_hi_reg;
        scan_seg_next = scan_seg_reg;
        decided_next  = decided_reg;
        res_fire      = 1'b0;
        res.status    = ST_OK;
        res.end_offset = '0;

        if (beat && !decided_reg) begin
            if (position_reg == {OFFSET_BITS{1'b1}}) begin
                // counter saturated: byte is not examined
                decided_next = 1'b1;
                res.status   = ST_TOO_LONG;
            end else begin
                position_next = pos_inc;
                case (phase_reg)
                    PH_SOI0: begin
                        if (data_byte == BYTE_FF) begin
                            phase_next = PH_SOI1;
                        end else begin
                            decided_next = 1'b1;
                            res.status   = ST_BAD_START;
                        end
                    end
                    PH_SOI1: begin
                        if (data_byte == BYTE_SOI) begin
                            phase_next = PH_NEED_FF;
                        end else begin
                            decided_next = 1'b1;
                            res.status   = ST_BAD_START;
                        end
                    end
                    PH_NEED_FF: begin
                        if (data_byte == BYTE_FF) begin
                            phase_next = PH_MARKER;
                        end else begin
                            decided_next = 1'b1;
                            res.status   = ST_BAD_STRUCT;
                        end
                    end
                    PH_MARKER: begin
                        do_marker = 1'b1;
                    end
                    PH_LEN_HI: begin
                        len_hi_next = data_byte;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (seg_len < 16'd2) begin
                            decided_next = 1'b1;
                            res.status   = ST_BAD_STRUCT;
                        end else begin
                            seg_rem_next = seg_len - 16'd2;
                            phase_next   = (seg_len == 16'd2) ? after_seg : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        seg_rem_next = seg_dec;
                        if (seg_dec == 16'd0) begin
                            phase_next = after_seg;
                        end
                    end
                    PH_ENTROPY: begin
                        if (data_byte == BYTE_FF) begin
                            phase_next = PH_ENT_FF;
                        end
                    end
                    PH_ENT_FF: begin
                        // stuffed zero and restart markers go back to data
                        if (data_byte == BYTE_ZERO || is_rst) begin
                            phase_next = PH_ENTROPY;
                        end else if (data_byte == BYTE_FF) begin
                            phase_next = PH_ENT_FF;
                        end else begin
                            do_marker = 1'b1;
                        end
                    end
                    default: begin
                        decided_next = 1'b1;
                        res.status   = ST_BAD_STRUCT;
                    end
                endcase

                if (do_marker) begin
                    if (data_byte == BYTE_FF) begin
                        phase_next = PH_MARKER;
                    end else if (data_byte == BYTE_EOI) begin
                        decided_next   = 1'b1;
                        res.status     = ST_OK;
                        res.end_offset = END_OFS_W'(pos_inc);
                    end else if (data_byte == BYTE_TEM || is_rst) begin
                        phase_next = PH_NEED_FF;
                    end else begin
                        scan_seg_next = (data_byte == BYTE_SOS);
                        phase_next    = PH_LEN_HI;
                    end
                end

                if (!decided_next && last_byte) begin
                    decided_next = 1'b1;
                    res.status   = (pos_inc < OFFSET_BITS'(4)) ? ST_BAD_START : ST_TRUNC;
                end
            end
            res_fire = decided_next;
        end

        if (beat && last_byte) begin
            phase_next    = PH_SOI0;
            position_next = '0;
            seg_rem_next  = '0;
            len_hi_next   = '0;
            scan_seg_next = 1'b0;
            decided_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SOI0;
            position_reg <= '0;
            seg_rem_reg  <= '0;
            len_hi_reg   <= '0;
            scan_seg_reg <= 1'b0;
            decided_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            seg_rem_reg  <= seg_rem_next;
            len_hi_reg   <= len_hi_next;
            scan_seg_reg <= scan_seg_next;
            decided_reg  <= decided_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_result_after_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        decided_reg |-> !res_fire)
        else $error("result after decision");

    a_restart_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && last_byte) |=> (phase_reg == PH_SOI0 && position_reg == '0 && !decided_reg))
        else $error("state not cleared after last beat");

    a_last_decides: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && last_byte && !decided_reg) |-> res_fire)
        else $error("last beat of undecided file gave no result");

    a_offset_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_fire && res.status != ST_OK) |-> (res.end_offset == '0))
        else $error("offset on error result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jfies_outbuf.sv =====
// ----------------------------------------------------------------------------
// jfies_outbuf
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps taking beats while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module jfies_outbuf (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire jfies_pkg::jfies_result_t push_data,
    output logic                        space_ok,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output jfies_pkg::jfies_result_t    m_data
);
    import jfies_pkg::*;

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    jfies_result_t out_data_reg, out_data_next;
    jfies_result_t skid_data_reg, skid_data_next;
    logic          pop;

    assign pop      = out_valid_reg && m_ready;
    assign space_ok = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // input is held off while the skid entry is full
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("result pushed into full buffer");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_first_image_end_scanner.sv =====
// ----------------------------------------------------------------------------
// jpeg_first_image_end_scanner
// Streams a JPEG file byte by byte, walks its marker segments and entropy
// data, and reports the offset just past the first EOI or an error status.
//
//   channel  dir  ports                          beat meaning
//   s_       in   s_data_byte, s_last_byte       one file byte, last mark
//   m_       out  m_status, m_end_offset         one decision per file
//
// One byte per cycle while s_ready is high: the marker state machine and the
// position counter update on each input beat until the file is decided, and
// a decision is registered into the result buffer. Reset (aresetn low,
// synchronous) clears the parser to await the start-of-image pair. Results go
// through a two-entry buffer, so s_ready drops only when both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_first_image_end_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_last_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [jfies_pkg::STATUS_W-1:0]        m_status,
    output logic [jfies_pkg::END_OFS_W-1:0]       m_end_offset
);
    import jfies_pkg::*;

    logic          beat;
    logic          res_fire;
    jfies_result_t res;
    jfies_result_t m_data;

    assign beat = s_valid && s_ready;

    jfies_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .res_fire  (res_fire),
        .res       (res)
    );

    jfies_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_fire),
        .push_data (res),
        .space_ok  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_status     = m_data.status;
    assign m_end_offset = m_data.end_offset;

`ifndef NO_ASSERTIONS
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_TOO_LONG))
        else $error("status code out of range");

    a_ok_offset_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (m_end_offset != '0 || OFFSET_BITS > END_OFS_W))
        else $error("end found with zero offset");
`endif

endmodule

`default_nettype wire

// ===== dv/jpeg_first_image_end_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_first_image_end_scanner_test
// Self-checking bench for the JPEG first-image end scanner. A short table of
// hand-built files comes first. After it come random files built from markers,
// length-counted segments and entropy data. Most of these are well formed; some
// are cut short, corrupted or pure noise. Every accepted beat goes through a
// behavioral scanner in the bench, and each result beat is compared in order
// against the table's entry or, for the rest, against what the scanner predicts.
// ----------------------------------------------------------------------------
module jpeg_first_image_end_scanner_test;
    import jfies_pkg::*;

    // narrower counter than the block default
    localparam int POS_BITS = 16;
    localparam logic [47:0] COUNT_LIMIT = (48'd1 << POS_BITS) - 48'd1;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 1900;
    localparam int RANDOM_FILES_MIN = 30;
    localparam int MAX_GAP = 17;

    localparam logic [7:0] MARK_APP0 = 8'hE0;

    typedef enum logic [3:0] {
        P_SOI_FF,
        P_SOI_D8,
        P_WANT_FF,
        P_MARKER,
        P_LEN_MSB,
        P_LEN_LSB,
        P_SKIP,
        P_ENTROPY,
        P_ENTROPY_FF
    } scan_phase_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        jfies_result_t res;
    } table_row_t;

    localparam table_row_t DIRECTED [28] = '{
        // bad first byte, then a tail that must be ignored
        '{BYTE_ZERO, 1'b0, 1'b1, '{ST_BAD_START, 32'd0}},
        '{BYTE_FF,   1'b1, 1'b0, '0},
        // file ends after three bytes
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOI,  1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b1, 1'b1, '{ST_BAD_START, 32'd0}},
        // no FF where a marker has to start
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOI,  1'b0, 1'b0, '0},
        '{BYTE_ZERO, 1'b1, 1'b1, '{ST_BAD_STRUCT, 32'd0}},
        // segment length below two
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOI,  1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{MARK_APP0, 1'b0, 1'b0, '0},
        '{8'h00,     1'b0, 1'b0, '0},
        '{8'h01,     1'b1, 1'b1, '{ST_BAD_STRUCT, 32'd0}},
        // empty scan header, then end of image
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOI,  1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOS,  1'b0, 1'b0, '0},
        '{8'h00,     1'b0, 1'b0, '0},
        '{8'h02,     1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_EOI,  1'b1, 1'b1, '{ST_OK, 32'd8}},
        // fill byte and TEM, then cut short
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_SOI,  1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b0, 1'b0, '0},
        '{BYTE_TEM,  1'b0, 1'b0, '0},
        '{BYTE_FF,   1'b1, 1'b1, '{ST_TRUNC, 32'd0}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_last_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATUS_W-1:0]  m_status;
    logic [END_OFS_W-1:0] m_end_offset;

    jfies_result_t expected_q[$];
    logic [7:0]    file_q[$];
    bit            hold_request = 1'b0;
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            bytes_sent = 0;
    int            files_sent = 0;
    int            status_hits [8];

    // scanner state kept by the bench
    scan_phase_t   scan_phase;
    logic [47:0]   byte_count;
    logic [15:0]   seg_left;
    logic [7:0]    len_msb;
    logic          in_scan;
    logic          settled;
    logic [2:0]    settled_status;
    logic [31:0]   settled_offset;

    always #5 aclk = ~aclk;

    jpeg_first_image_end_scanner #(
        .OFFSET_BITS(POS_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_end_offset(m_end_offset)
    );

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic append_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    task automatic expect_result(input jfies_result_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic clear_scanner();
        scan_phase = P_SOI_FF;
        byte_count = '0;
        seg_left = '0;
        len_msb = '0;
        in_scan = 1'b0;
        settled = 1'b0;
        settled_status = ST_OK;
        settled_offset = '0;
    endtask

    task automatic conclude(input logic [2:0] st);
        settled = 1'b1;
        settled_status = st;
        settled_offset = byte_count[31:0];
    endtask

    task automatic on_marker(input logic [7:0] b);
        if (b == BYTE_FF) begin
            scan_phase = P_MARKER;
        end else if (b == BYTE_EOI) begin
            conclude(ST_OK);
        end else if (b == BYTE_TEM || (b >= BYTE_RST0 && b <= BYTE_RST7)) begin
            scan_phase = P_WANT_FF;
        end else begin
            in_scan = (b == BYTE_SOS);
            scan_phase = P_LEN_MSB;
        end
    endtask

    task automatic predict_end(input logic [7:0] b, input logic lst,
                               output logic got, output jfies_result_t res);
        logic [15:0] seg_len;
        got = 1'b0;
        res = '0;
        if (!settled) begin
            if (byte_count >= COUNT_LIMIT) begin
                conclude(ST_TOO_LONG);
            end else begin
                byte_count = byte_count + 48'd1;
                case (scan_phase)
                    P_SOI_FF: begin
                        if (b == BYTE_FF) scan_phase = P_SOI_D8;
                        else conclude(ST_BAD_START);
                    end
                    P_SOI_D8: begin
                        if (b == BYTE_SOI) scan_phase = P_WANT_FF;
                        else conclude(ST_BAD_START);
                    end
                    P_WANT_FF: begin
                        if (b == BYTE_FF) scan_phase = P_MARKER;
                        else conclude(ST_BAD_STRUCT);
                    end
                    P_MARKER: on_marker(b);
                    P_LEN_MSB: begin
                        len_msb = b;
                        scan_phase = P_LEN_LSB;
                    end
                    P_LEN_LSB: begin
                        seg_len = {len_msb, b};
                        if (seg_len < 16'd2) begin
                            conclude(ST_BAD_STRUCT);
                        end else begin
                            seg_left = seg_len - 16'd2;
                            if (seg_left == 16'd0) scan_phase = in_scan ? P_ENTROPY : P_WANT_FF;
                            else scan_phase = P_SKIP;
                        end
                    end
                    P_SKIP: begin
                        seg_left = seg_left - 16'd1;
                        if (seg_left == 16'd0) scan_phase = in_scan ? P_ENTROPY : P_WANT_FF;
                    end
                    P_ENTROPY: begin
                        if (b == BYTE_FF) scan_phase = P_ENTROPY_FF;
                    end
                    P_ENTROPY_FF: begin
                        // stuffed zero and restarts stay in the scan, extra FF waits
                        if (b == BYTE_ZERO || (b >= BYTE_RST0 && b <= BYTE_RST7)) begin
                            scan_phase = P_ENTROPY;
                        end else if (b != BYTE_FF) begin
                            on_marker(b);
                        end
                    end
                    default: conclude(ST_BAD_STRUCT);
                endcase
            end
            if (!settled && lst) conclude(byte_count < 48'd4 ? ST_BAD_START : ST_TRUNC);
            if (settled) begin
                got = 1'b1;
                res.status = settled_status;
                res.end_offset = (settled_status == ST_OK) ? settled_offset : 32'd0;
            end
        end
        if (lst) clear_scanner();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst, input int gap,
                             output logic got, output jfies_result_t res);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_end(b, lst, got, res);
        bytes_sent++;
        if (lst) files_sent++;
    endtask

    task automatic send_file(input bit with_gaps);
        logic got;
        jfies_result_t res;
        foreach (file_q[i]) begin
            send_byte(file_q[i], i == file_q.size() - 1,
                      with_gaps ? $urandom_range(0, MAX_GAP) : 0, got, res);
            if (got) expect_result(res);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic put_marker(input logic [7:0] mk);
        append_byte(BYTE_FF);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) append_byte(BYTE_FF);
        end
        append_byte(mk);
    endtask

    task automatic put_segment(input logic [7:0] mk);
        int len;
        len = 2 + (($urandom_range(0, 23) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 10));
        put_marker(mk);
        append_byte(8'(len >> 8));
        append_byte(8'(len));
        repeat (len - 2) append_byte(8'($urandom_range(0, 255)));
    endtask

    // entropy data that never forms a real marker
    task automatic put_entropy(input int chunks);
        repeat (chunks) begin
            case ($urandom_range(0, 9))
                0: begin
                    append_byte(BYTE_FF);
                    append_byte(BYTE_ZERO);
                end
                1: begin
                    append_byte(BYTE_FF);
                    append_byte(BYTE_RST0 + 8'($urandom_range(0, 7)));
                end
                2: begin
                    repeat ($urandom_range(2, 4)) append_byte(BYTE_FF);
                    append_byte(BYTE_ZERO);
                end
                default: append_byte(8'($urandom_range(0, 254)));
            endcase
        end
    endtask

    task automatic build_file();
        int cut;
        logic [7:0] mk;
        file_q.delete();
        append_byte(BYTE_FF);
        append_byte(BYTE_SOI);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
                0: begin
                    if ($urandom_range(0, 1) == 1) put_marker(BYTE_TEM);
                    else put_marker(BYTE_RST0 + 8'($urandom_range(0, 7)));
                end
                1: begin
                    put_segment(BYTE_SOS);
                    put_entropy($urandom_range(0, 24));
                end
                default: begin
                    do mk = 8'($urandom_range(0, 254));
                    while (mk == BYTE_EOI || mk == BYTE_SOS || mk == BYTE_TEM ||
                           (mk >= BYTE_RST0 && mk <= BYTE_RST7));
                    put_segment(mk);
                end
            endcase
        end
        put_marker(BYTE_EOI);
        repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
        // about one file in three is damaged
        case ($urandom_range(0, 11))
            0, 1: begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut) void'(file_q.pop_back());
            end
            2: file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
            3: begin
                file_q.delete();
                repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) file_q[0] = BYTE_FF;
            end
            default: ;
        endcase
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit rx_gaps;
        jfies_result_t want;
        stall_left = 0;
        hold_left = 0;
        rx_gaps = 1'b1;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (hold_request) begin
                    hold_request = 1'b0;
                    hold_left = HOLD_CYCLES;
                end else if (hold_left > 0) begin
                    hold_left--;
                end
                if (m_valid && m_ready) begin
                    results_seen++;
                    status_hits[m_status]++;
                    if (expected_q.size() == 0) begin
                        report_mismatch($sformatf("unexpected beat, status %0d offset %0d",
                                                  m_status, m_end_offset));
                    end else begin
                        want = expected_q.pop_front();
                        if (m_status !== want.status)
                            report_mismatch($sformatf("status %0d, wanted %0d",
                                                      m_status, want.status));
                        if (m_end_offset !== want.end_offset)
                            report_mismatch($sformatf("end_offset %0d, wanted %0d",
                                                      m_end_offset, want.end_offset));
                    end
                    rx_gaps = ($urandom_range(0, 2) != 0);
                    stall_left = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
                end else if (stall_left > 0) begin
                    stall_left--;
                end
                m_ready <= (stall_left == 0 && hold_left == 0);
            end
        end
    end

    initial begin : stimulus
        logic got;
        jfies_result_t res;
        int random_start;
        int random_files;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_last_byte <= 1'b0;
        clear_scanner();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].data, DIRECTED[i].last, $urandom_range(0, MAX_GAP), got, res);
            if (DIRECTED[i].typed) expect_result(DIRECTED[i].res);
            else if (got) expect_result(res);
        end
        wait_for_results();

        // sink holds off while one-byte bad files pile up and stall the input
        hold_request = 1'b1;
        repeat (8) begin
            send_byte(8'($urandom_range(0, 254)), 1'b1, 0, got, res);
            if (got) expect_result(res);
        end
        wait_for_results();

        random_start = bytes_sent;
        random_files = 0;
        while (bytes_sent - random_start < RANDOM_BYTES || random_files < RANDOM_FILES_MIN) begin
            build_file();
            send_file($urandom_range(0, 3) != 0);
            random_files++;
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        $display("%0d files, %0d beats in, %0d results checked, %0d mismatches",
                 files_sent, bytes_sent, results_seen, mismatch_count);
        $display("status mix: end %0d, bad start %0d, structure %0d, truncated %0d, long %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_START], status_hits[ST_BAD_STRUCT],
                 status_hits[ST_TRUNC], status_hits[ST_TOO_LONG]);
        if (mismatch_count == 0) begin
            $display("jpeg_first_image_end_scanner_test passed");
        end else begin
            $display("jpeg_first_image_end_scanner_test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("timeout with %0d results still due", expected_q.size());
        $display("jpeg_first_image_end_scanner_test failed");
        $finish;
    end

endmodule
